@@ rtl/core/mfm_pkg.sv @@
// ----------------------------------------------------------------------------
// mfm_pkg
// shared widths, register codes, reset values and control types of the
// mains frequency meter
// ----------------------------------------------------------------------------
package mfm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;

  localparam int RATE_BITS    = 24;
  localparam int THR_BITS     = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int TIMEOUT_BITS = 4;
  localparam int AVG_BITS     = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = RATE_BITS;

  // rate << FRAC_BITS over 2 * count equals rate << (FRAC_BITS - 1) over count
  localparam int HALF_SHIFT = FRAC_BITS - 1;
  localparam int DIV_BITS   = RATE_BITS + HALF_SHIFT;
  localparam int DIV_STEPS  = DIV_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam int LIMIT_BITS = RATE_BITS + TIMEOUT_BITS;
  localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int PROD_BITS  = WEIGHT_BITS + 1 + AVG_BITS + 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_SECONDS  = 3'd4;

  // reset values
  localparam logic [RATE_BITS-1:0]    RST_SAMPLE_RATE      = 24'd10000;
  localparam logic [THR_BITS-1:0]     RST_LOW_THRESHOLD    = 16'hFC18;  // -1000
  localparam logic [THR_BITS-1:0]     RST_HIGH_THRESHOLD   = 16'd1000;
  localparam logic [WEIGHT_BITS-1:0]  RST_SMOOTHING_WEIGHT = 16'd459;   // about 0.007
  localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT_SECONDS  = 4'd5;
  localparam logic [AVG_BITS-1:0]     RST_AVERAGE          = 32'd3276800; // 50.0 hz

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;     // take the request, update phase and counters
    logic div_step;   // one restoring division step
    logic mul;        // weight times difference
    logic add;        // fold product into the average
    logic out_load;   // load the output register
  } mfm_cmd_t;

  typedef struct packed {
    logic fold_needed; // request ends a nonzero half period
  } mfm_sts_t;

endpackage

@@ rtl/core/mfm_dp.sv @@
// ----------------------------------------------------------------------------
// mfm_dp
// datapath: phase tracking, half-period counters, timeout, bit-serial
// divider, averaging multiplier and output register
// ----------------------------------------------------------------------------
module mfm_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mfm_pkg::mfm_cmd_t                    cmd_i,
  output mfm_pkg::mfm_sts_t                    sts_o,
  input  logic signed [mfm_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic [mfm_pkg::RATE_BITS-1:0]        sample_rate_i,
  input  logic signed [mfm_pkg::THR_BITS-1:0]  low_threshold_i,
  input  logic signed [mfm_pkg::THR_BITS-1:0]  high_threshold_i,
  input  logic [mfm_pkg::WEIGHT_BITS-1:0]      smoothing_weight_i,
  input  logic [mfm_pkg::TIMEOUT_BITS-1:0]     timeout_seconds_i,
  output logic [mfm_pkg::AVG_BITS-1:0]         avg_freq_o,
  output logic                                 timeout_flag_o
);
  import mfm_pkg::*;

  logic                  phase_q, phase_d;
  logic [COUNT_BITS-1:0] low_cnt_q, low_cnt_d;
  logic [COUNT_BITS-1:0] high_cnt_q, high_cnt_d;
  logic [AVG_BITS-1:0]   avg_q, avg_d;
  logic                  flag_q, flag_d;
  logic [COUNT_BITS-1:0] divisor_q;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [DIV_BITS-1:0]   quo_q, quo_d;
  logic signed [PROD_BITS-1:0] prod_q, prod_d;
  logic [AVG_BITS-1:0]   out_avg_q;
  logic                  out_flag_q;

  logic                  hi_cross, lo_cross;
  logic [COUNT_BITS-1:0] fold_cnt;
  logic [COUNT_BITS-1:0] low_inc, high_inc;
  logic [LIMIT_BITS-1:0] limit;
  logic                  over;

  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS+1:0] trial;
  logic                  ge;
  logic [AVG_BITS-1:0]   half;
  logic signed [AVG_BITS:0]    diff;
  logic signed [PROD_BITS-1:0] prod_sh;

  // phase and counter update of the incoming request
  always_comb begin
    hi_cross = !phase_q && (sample_i >= high_threshold_i);
    lo_cross = phase_q && (sample_i < low_threshold_i);
    low_inc  = (low_cnt_q == '1) ? low_cnt_q : low_cnt_q + 1'b1;
    high_inc = (high_cnt_q == '1) ? high_cnt_q : high_cnt_q + 1'b1;
    phase_d    = phase_q;
    low_cnt_d  = low_cnt_q;
    high_cnt_d = high_cnt_q;
    fold_cnt   = '0;
    if (!phase_q) begin
      if (hi_cross) begin
        fold_cnt   = low_cnt_q;
        low_cnt_d  = '0;
        phase_d    = 1'b1;
        high_cnt_d = high_inc;
      end else begin
        low_cnt_d = low_inc;
      end
    end else begin
      if (lo_cross) begin
        fold_cnt   = high_cnt_q;
        high_cnt_d = '0;
        phase_d    = 1'b0;
        low_cnt_d  = low_inc;
      end else begin
        high_cnt_d = high_inc;
      end
    end
    limit = LIMIT_BITS'(sample_rate_i) * LIMIT_BITS'(timeout_seconds_i);
    over  = (CMP_BITS'(low_cnt_d) > CMP_BITS'(limit)) ||
            (CMP_BITS'(high_cnt_d) > CMP_BITS'(limit));
    flag_d = over;
    if (over) begin
      low_cnt_d  = '0;
      high_cnt_d = '0;
    end
  end

  assign sts_o.fold_needed = (hi_cross || lo_cross) && (fold_cnt != '0);

  // restoring division, one quotient bit per step
  always_comb begin
    shifted = {rem_q, quo_q[DIV_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, divisor_q};
    ge      = !trial[COUNT_BITS+1];
    rem_d   = ge ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    quo_d   = {quo_q[DIV_BITS-2:0], ge};
  end

  // saturate the quotient to 32 bits
  assign half = (quo_q[DIV_BITS-1:AVG_BITS] != '0) ? '1 : quo_q[AVG_BITS-1:0];

  // avg + floor(w * (half - avg) / 2^16)
  assign diff    = $signed({1'b0, half}) - $signed({1'b0, avg_q});
  assign prod_d  = $signed({1'b0, smoothing_weight_i}) * diff;
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign avg_d   = avg_q + prod_sh[AVG_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
      avg_q      <= RST_AVERAGE;
      flag_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        phase_q    <= phase_d;
        low_cnt_q  <= low_cnt_d;
        high_cnt_q <= high_cnt_d;
        flag_q     <= flag_d;
      end
      if (cmd_i.add) begin
        avg_q <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      divisor_q <= fold_cnt;
      rem_q     <= '0;
      quo_q     <= {sample_rate_i, {HALF_SHIFT{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      out_avg_q  <= avg_q;
      out_flag_q <= flag_q;
    end
  end

  assign avg_freq_o     = out_avg_q;
  assign timeout_flag_o = out_flag_q;

endmodule

@@ rtl/core/mfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfm_ctrl
// sequencer: takes a request, runs the divider and the averaging steps
// when a half period ends, and hands the result to the output register
// ----------------------------------------------------------------------------
module mfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  mfm_pkg::mfm_sts_t sts_i,
  output mfm_pkg::mfm_cmd_t cmd_o
);
  import mfm_pkg::*;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        step_d       = '0;
        if (in_valid_i) begin
          state_d = sts_i.fold_needed ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_fold_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept && sts_i.fold_needed |=> state_q == ST_DIV)
    else $error("fold request did not start the divider");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> step_q <= LAST_STEP)
    else $error("divider step count out of range");

  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && step_q == LAST_STEP |=> state_q == ST_MUL)
    else $error("divider did not hand over to the multiplier");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> state_q == ST_DONE && $past(state_q) != ST_IDLE ||
                       state_q == ST_DONE && $past(cmd_o.accept))
    else $error("result loaded outside the done state");
`endif

endmodule

@@ rtl/core/mains_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// mains_frequency_meter
// hysteresis zero-crossing frequency meter with exponential averaging
// ----------------------------------------------------------------------------
// one signed sample per request; each request yields one result with the
// smoothed frequency (unsigned Q16.16 hertz) and a timeout flag
// a request that does not end a nonzero half period is taken, then loaded
// into the output register once that is free; one that ends a nonzero half
// period runs a bit-serial restoring divider of 39 steps, a multiply step
// and an accumulate step, so the divider loop sets the worst case rate
// the output register keeps a finished result while the next request is
// taken; configuration writes are always taken (cfg_ready_o is tied high),
// write only while no request is in flight
// ----------------------------------------------------------------------------
module mains_frequency_meter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [mfm_pkg::SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [mfm_pkg::AVG_BITS-1:0]           avg_freq_o,
  output logic                                   timeout_flag_o,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mfm_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [mfm_pkg::CFG_DATA_BITS-1:0]      cfg_data_i
);
  import mfm_pkg::*;

  // configuration registers
  logic [RATE_BITS-1:0]       sample_rate_q;
  logic signed [THR_BITS-1:0] low_threshold_q;
  logic signed [THR_BITS-1:0] high_threshold_q;
  logic [WEIGHT_BITS-1:0]     smoothing_weight_q;
  logic [TIMEOUT_BITS-1:0]    timeout_seconds_q;

  // controller to datapath
  mfm_cmd_t cmd;
  mfm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q      <= RST_SAMPLE_RATE;
      low_threshold_q    <= RST_LOW_THRESHOLD;
      high_threshold_q   <= RST_HIGH_THRESHOLD;
      smoothing_weight_q <= RST_SMOOTHING_WEIGHT;
      timeout_seconds_q  <= RST_TIMEOUT_SECONDS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_RATE:      sample_rate_q      <= cfg_data_i[RATE_BITS-1:0];
        REG_LOW_THRESHOLD:    low_threshold_q    <= cfg_data_i[THR_BITS-1:0];
        REG_HIGH_THRESHOLD:   high_threshold_q   <= cfg_data_i[THR_BITS-1:0];
        REG_SMOOTHING_WEIGHT: smoothing_weight_q <= cfg_data_i[WEIGHT_BITS-1:0];
        REG_TIMEOUT_SECONDS:  timeout_seconds_q  <= cfg_data_i[TIMEOUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  mfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // phase tracking, divider, averaging and output register
  mfm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sample_i           (sample_i),
    .sample_rate_i      (sample_rate_q),
    .low_threshold_i    (low_threshold_q),
    .high_threshold_i   (high_threshold_q),
    .smoothing_weight_i (smoothing_weight_q),
    .timeout_seconds_i  (timeout_seconds_q),
    .avg_freq_o         (avg_freq_o),
    .timeout_flag_o     (timeout_flag_o)
  );

endmodule

@@ bench/mfm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfm_checker
// watches the sample, result and configuration channels of the meter, keeps
// its own copy of the registers, phase, counters and average, predicts one
// reading per accepted sample and compares each accepted result with the
// oldest waiting prediction
// ----------------------------------------------------------------------------
module mfm_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [mfm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic [mfm_pkg::AVG_BITS-1:0]           avg_freq_i,
  input  logic                                   timeout_flag_i,
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_ready_i,
  input  logic [mfm_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [mfm_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  import mfm_pkg::*;

  typedef struct packed {
    logic [AVG_BITS-1:0] avg;
    logic                flag;
  } reading_t;

  // register copies
  logic [RATE_BITS-1:0]           rate;
  logic signed [THR_BITS-1:0]     lo_thr;
  logic signed [THR_BITS-1:0]     hi_thr;
  logic [WEIGHT_BITS-1:0]         weight;
  logic [TIMEOUT_BITS-1:0]        timeout_s;

  // meter state
  logic                           in_high;
  logic [COUNT_BITS-1:0]          low_cnt;
  logic [COUNT_BITS-1:0]          high_cnt;
  logic [AVG_BITS-1:0]            avg;

  reading_t expected_readings[$];
  int       fails;
  int       result_idx;

  initial begin
    fails      = 0;
    result_idx = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_idx, msg);
    fails++;
  endtask

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // fold the ended half period into the average, skipped for a zero count
  task automatic fold_half_period(input logic [COUNT_BITS-1:0] count);
    logic [63:0] half;
    logic [63:0] acc;
    if (count == '0) return;
    half = (64'(rate) << FRAC_BITS) / (64'(count) << 1);
    if (half > 64'hFFFF_FFFF) half = 64'hFFFF_FFFF;
    acc = 64'(weight) * half + (64'd65536 - 64'(weight)) * 64'(avg);
    avg = acc[FRAC_BITS +: AVG_BITS];
  endtask

  task automatic advance_meter(input logic signed [SAMPLE_BITS-1:0] s,
                               output reading_t r);
    logic [63:0] limit;
    r.flag = 1'b0;
    if (!in_high) begin
      if (s >= hi_thr) begin
        fold_half_period(low_cnt);
        low_cnt  = '0;
        in_high  = 1'b1;
        high_cnt = bump(high_cnt);
      end else begin
        low_cnt = bump(low_cnt);
      end
    end else begin
      if (s < lo_thr) begin
        fold_half_period(high_cnt);
        high_cnt = '0;
        in_high  = 1'b0;
        low_cnt  = bump(low_cnt);
      end else begin
        high_cnt = bump(high_cnt);
      end
    end
    // timeout is judged after the phase update of the same sample
    limit = 64'(rate) * 64'(timeout_s);
    if (64'(low_cnt) > limit || 64'(high_cnt) > limit) begin
      low_cnt  = '0;
      high_cnt = '0;
      r.flag   = 1'b1;
    end
    r.avg = avg;
  endtask

  task automatic write_shadow(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SAMPLE_RATE:      rate      = data[RATE_BITS-1:0];
      REG_LOW_THRESHOLD:    lo_thr    = data[THR_BITS-1:0];
      REG_HIGH_THRESHOLD:   hi_thr    = data[THR_BITS-1:0];
      REG_SMOOTHING_WEIGHT: weight    = data[WEIGHT_BITS-1:0];
      REG_TIMEOUT_SECONDS:  timeout_s = data[TIMEOUT_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      rate      = RST_SAMPLE_RATE;
      lo_thr    = RST_LOW_THRESHOLD;
      hi_thr    = RST_HIGH_THRESHOLD;
      weight    = RST_SMOOTHING_WEIGHT;
      timeout_s = RST_TIMEOUT_SECONDS;
      in_high   = 1'b0;
      low_cnt   = '0;
      high_cnt  = '0;
      avg       = RST_AVERAGE;
      expected_readings.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_shadow(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        advance_meter(sample_i, want);
        expected_readings.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no sample waiting");
        end else begin
          want = expected_readings.pop_front();
          if (avg_freq_i !== want.avg)
            report_mismatch($sformatf("avg_freq got %0d, expected %0d",
                                      avg_freq_i, want.avg));
          if (timeout_flag_i !== want.flag)
            report_mismatch($sformatf("timeout_flag got %0b, expected %0b",
                                      timeout_flag_i, want.flag));
        end
        result_idx++;
      end
    end
    pending_o    <= expected_readings.size();
    fail_count_o <= fails;
  end

endmodule

@@ bench/mains_frequency_meter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_frequency_meter_test
// short directed run, then random half waves under several register settings
// with random gaps on the sample side and random stalls on the result side;
// the checker predicts every reading, this module builds stimulus and gives
// the verdict
// ----------------------------------------------------------------------------
module mains_frequency_meter_test;
  import mfm_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_LIMIT    = 5000;  // cycles with no request moving anywhere
  localparam int DRAIN_CYCLES  = 60;    // a bit past the longest divide
  localparam int PRESSURE_HOLD = 600;   // long result-side hold-off
  localparam int PRESSURE_AT   = 300;   // results taken before the hold-off
  localparam int PHASE_ITEMS   = 150;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [AVG_BITS-1:0]           avg_freq_o;
  logic                          timeout_flag_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i = REG_SAMPLE_RATE;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i  = '0;

  int fail_count;
  int pending;
  int results_taken = 0;

  // thresholds as last written, used to shape the waveform
  int cur_lo = -1000;
  int cur_hi = 1000;

  always #1 clk_i = ~clk_i;

  mains_frequency_meter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .avg_freq_o     (avg_freq_o),
    .timeout_flag_o (timeout_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  mfm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .avg_freq_i     (avg_freq_o),
    .timeout_flag_i (timeout_flag_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // count taken results, the receiver uses it to time the long hold-off
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) results_taken <= results_taken + 1;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // one sample request; called at a rising edge, returns at the accepting edge
  task automatic send_sample(input int s, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= SAMPLE_BITS'(s);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // back-to-back register writes keep valid high between them
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // rewrite all five registers once the meter has drained
  task automatic set_config(input int rate, input int lo, input int hi,
                            input int w, input int tmo);
    logic [THR_BITS-1:0] lo_bits;
    logic [THR_BITS-1:0] hi_bits;
    lo_bits = THR_BITS'(lo);
    hi_bits = THR_BITS'(hi);
    in_valid_i <= 1'b0;
    // pending count is registered, so it lags behind the last acceptance
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    write_register(REG_SAMPLE_RATE,      CFG_DATA_BITS'(RATE_BITS'(rate)));
    write_register(REG_LOW_THRESHOLD,    CFG_DATA_BITS'(lo_bits));
    write_register(REG_HIGH_THRESHOLD,   CFG_DATA_BITS'(hi_bits));
    write_register(REG_SMOOTHING_WEIGHT, CFG_DATA_BITS'(WEIGHT_BITS'(w)));
    write_register(REG_TIMEOUT_SECONDS,  CFG_DATA_BITS'(TIMEOUT_BITS'(tmo)));
    cfg_valid_i <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // a level for the wanted half wave, with some noise and in-band values
  function automatic int pick_level(input bit up);
    int r;
    int lo_b;
    int hi_b;
    r = $urandom_range(0, 99);
    if (r < 8) return int'($urandom_range(0, 65535)) - 32768;
    if (r < 14) begin
      lo_b = (cur_lo < cur_hi) ? cur_lo : cur_hi;
      hi_b = (cur_lo < cur_hi) ? cur_hi : cur_lo;
      return lo_b + int'($urandom_range(0, hi_b - lo_b));
    end
    if (up) return cur_hi + int'($urandom_range(0, 32767 - cur_hi));
    // nothing lies below the most negative low threshold
    if (cur_lo == -32768) return -32768;
    return -32768 + int'($urandom_range(0, cur_lo + 32767));
  endfunction

  // alternating half waves of random length with random content
  task automatic run_wave(input int n_items, input int max_half);
    bit up;
    int left;
    bit steady;
    up     = $urandom_range(0, 1);
    left   = $urandom_range(1, max_half);
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      send_sample(pick_level(up), steady ? 0 : pick_gap());
      left--;
      if (left == 0) begin
        up   = !up;
        left = $urandom_range(1, max_half);
      end
    end
  endtask

  task automatic run_phase(input int rate, input int lo, input int hi, input int w,
                           input int tmo, input int max_half);
    set_config(rate, lo, hi, w, tmo);
    run_wave(PHASE_ITEMS, max_half);
  endtask

  // result side: ready bursts of random length, random stalls, one long hold
  initial begin : result_sink
    int  on_len;
    int  off_len;
    bit  held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      on_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                                            : $urandom_range(50, 300);
      out_ready_i <= 1'b1;
      repeat (on_len) @(posedge clk_i);
      if (!held && results_taken >= PRESSURE_AT) begin
        // sender keeps offering meanwhile, so the meter backs up
        off_len = PRESSURE_HOLD;
        held    = 1'b1;
      end else begin
        off_len = pick_gap();
      end
      if (off_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  // end the run if nothing moves on any channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int rate;
    int lo;
    int hi;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first crossing ends an empty half period, so no fold
    send_sample(32767, 0);
    send_sample(-32768, 0);   // back to low after one high sample
    send_sample(0, 0);
    send_sample(-1, 0);
    send_sample(999, 0);      // just under the high threshold
    send_sample(1000, 0);     // exactly at it flips
    send_sample(-1000, 0);    // at the low threshold stays high
    send_sample(-1001, 0);    // just below flips
    send_sample(-1000, 0);
    send_sample(32767, 0);
    send_sample(21845, 0);
    send_sample(-21846, 0);

    // inverted thresholds, full weight, limit of one sample
    set_config(1, 500, -500, 65535, 1);
    send_sample(0, 0);        // low to high since 0 >= -500
    send_sample(0, 0);        // high to low since 0 < 500
    send_sample(-32768, 0);   // low phase runs past the limit
    send_sample(-32768, 0);
    send_sample(32767, 0);    // crossing after a clear and one low sample: nonzero half
    send_sample(32767, 0);
    send_sample(32767, 0);
    send_sample(-500, 0);
    send_sample(499, 0);
    send_sample(500, 0);

    // fixed settings, the register extremes among them
    run_phase(10000, -1000, 1000, 459, 5, 120);
    run_phase(1, -32768, 32767, 0, 1, 4);
    run_phase(16777215, 32767, -32768, 65535, 15, 30);
    run_phase(7, -3, 3, 32768, 3, 30);

    // random settings, small rates often so that timeouts show up
    repeat (4) begin
      rate = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64)
                                         : $urandom_range(1, 16777215);
      lo = int'($urandom_range(0, 65535)) - 32768;
      hi = int'($urandom_range(0, 65535)) - 32768;
      run_phase(rate, lo, hi, $urandom_range(0, 65535), $urandom_range(1, 15),
                $urandom_range(1, 60));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
